@@ src/tdt_pkg.sv @@
// Shared types and constants for the task dependence tracker.
// Used by tdt_ctrl, tdt_datapath and task_dependence_tracker_top; no dependencies.
package tdt_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int LIST_DEPTH = 16;

   localparam int FIELD_W = 6;
   localparam int PEND_W  = 6;
   localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int TOP_W   = $clog2(SLOT_COUNT + 1);
   localparam int LEN_W   = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int DEP_N   = SLOT_COUNT * LIST_DEPTH;
   localparam int DEP_AW  = (DEP_N > 1) ? $clog2(DEP_N) : 1;
   // range checks compare the 6-bit slot fields against up to 1024 slots
   localparam int CMP_W   = 11;

   localparam logic [1:0] CMD_ADD_TASK = 2'd0;
   localparam logic [1:0] CMD_ADD_EDGE = 2'd1;
   localparam logic [1:0] CMD_FINISH   = 2'd2;

   typedef enum logic [1:0] {
      KIND_GRANT = 2'd0,
      KIND_READY = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      SEL_ZERO,
      SEL_PROD,
      SEL_TASK,
      SEL_STACK,
      SEL_CUR,
      SEL_DEP
   } sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_POP,
      OP_GRANT,
      OP_EDGE_RD,
      OP_EDGE_ADD,
      OP_LEN_RD,
      OP_LEN_SET,
      OP_DEP_RD,
      OP_DEP_UPD,
      OP_FREE
   } dp_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_T_POP,
      S_T_GRANT,
      S_T_READY,
      S_E_RD,
      S_E_ADD,
      S_F_LEN,
      S_F_SET,
      S_F_DEP,
      S_F_UPD,
      S_F_FREE,
      S_ERR
   } state_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
      kind_type  kind;
      sel_type   sel;
      logic      last;
   } dp_cmd_type;

   typedef struct packed {
      logic pred_zero;
      logic prod_bad;
      logic task_bad;
      logic dep_bad;
      logic stack_empty;
      logic stack_full;
      logic edge_hit;
      logic list_full;
      logic len_zero;
      logic dep_last;
      logic pend_one;
      logic out_free;
   } dp_status_type;

endpackage

@@ src/task_dependence_tracker_top.sv @@
// Task dependence tracker: one request at a time, each stepped through the sequencer's
// states; finish walks up to sixteen dependents, reading each slot table through its
// single read port. A beat waits while the result register still holds an unaccepted
// beat (rsp_ready low). Synchronous reset empties the pending, length and edge tables
// through valid bits at once and refills the free stack; no clearing pass.
// Depends on tdt_pkg, tdt_ctrl, tdt_datapath.
module task_dependence_tracker_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_cmd,
   input  logic [tdt_pkg::FIELD_W-1:0]  req_pred_count,
   input  logic [tdt_pkg::FIELD_W-1:0]  req_producer_slot,
   input  logic [tdt_pkg::FIELD_W-1:0]  req_task_slot,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_kind,
   output logic [tdt_pkg::FIELD_W-1:0]  rsp_slot_id,
   output logic                         rsp_last
);
   import tdt_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   tdt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_pred_count    (req_pred_count),
      .req_producer_slot (req_producer_slot),
      .req_task_slot     (req_task_slot),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_slot_id       (rsp_slot_id),
      .rsp_last          (rsp_last)
   );

endmodule

@@ src/tdt_ctrl.sv @@
// Sequencer for the task dependence tracker: steps each command through the datapath.
// Depends on tdt_pkg.
module tdt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_cmd,
   output logic                  req_ready,
   input  tdt_pkg::dp_status_type dp_status,
   output tdt_pkg::dp_cmd_type    dp_cmd
);
   import tdt_pkg::*;

   state_type state_ff, state_in;
   logic      ready_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a dependent only produces a beat when its count drops to zero
   assign ready_emit = !dp_status.dep_bad && dp_status.pend_one;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_ADD_TASK: state_in = S_T_POP;
                  CMD_ADD_EDGE: state_in = S_E_RD;
                  CMD_FINISH:   state_in = S_F_LEN;
                  default:      state_in = S_ERR;
               endcase
            end
         end
         S_T_POP: begin
            if (!dp_status.stack_empty) begin
               state_in = S_T_GRANT;
            end else if (dp_status.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_T_GRANT: begin
            if (dp_status.out_free) begin
               state_in = dp_status.pred_zero ? S_T_READY : S_IDLE;
            end
         end
         S_T_READY: begin
            if (dp_status.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_E_RD: begin
            if (!dp_status.prod_bad && !dp_status.task_bad) begin
               state_in = S_E_ADD;
            end else if (dp_status.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_E_ADD: begin
            if (dp_status.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_F_LEN: begin
            if (!dp_status.task_bad) begin
               state_in = S_F_SET;
            end else if (dp_status.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_F_SET: begin
            state_in = dp_status.len_zero ? S_F_FREE : S_F_DEP;
         end
         S_F_DEP: begin
            state_in = S_F_UPD;
         end
         S_F_UPD: begin
            if (!ready_emit || dp_status.out_free) begin
               state_in = dp_status.dep_last ? S_F_FREE : S_F_DEP;
            end
         end
         S_F_FREE: begin
            if (dp_status.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_ERR: begin
            if (dp_status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      dp_cmd.op   = OP_NONE;
      dp_cmd.emit = 1'b0;
      dp_cmd.kind = KIND_ERROR;
      dp_cmd.sel  = SEL_ZERO;
      dp_cmd.last = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.op = OP_LOAD;
            end
         end
         S_T_POP: begin
            if (!dp_status.stack_empty) begin
               dp_cmd.op = OP_POP;
            end else begin
               dp_cmd.emit = dp_status.out_free;
            end
         end
         S_T_GRANT: begin
            dp_cmd.kind = KIND_GRANT;
            dp_cmd.sel  = SEL_STACK;
            dp_cmd.last = !dp_status.pred_zero;
            if (dp_status.out_free) begin
               dp_cmd.op   = OP_GRANT;
               dp_cmd.emit = 1'b1;
            end
         end
         S_T_READY: begin
            dp_cmd.kind = KIND_READY;
            dp_cmd.sel  = SEL_CUR;
            dp_cmd.emit = dp_status.out_free;
         end
         S_E_RD: begin
            if (dp_status.prod_bad) begin
               dp_cmd.sel  = SEL_PROD;
               dp_cmd.emit = dp_status.out_free;
            end else if (dp_status.task_bad) begin
               dp_cmd.sel  = SEL_TASK;
               dp_cmd.emit = dp_status.out_free;
            end else begin
               dp_cmd.op = OP_EDGE_RD;
            end
         end
         S_E_ADD: begin
            dp_cmd.emit = dp_status.out_free;
            priority if (dp_status.edge_hit) begin
               dp_cmd.kind = KIND_DONE;
               dp_cmd.sel  = SEL_TASK;
            end else if (dp_status.list_full) begin
               dp_cmd.sel  = SEL_PROD;
            end else begin
               dp_cmd.kind = KIND_DONE;
               dp_cmd.sel  = SEL_TASK;
               if (dp_status.out_free) begin
                  dp_cmd.op = OP_EDGE_ADD;
               end
            end
         end
         S_F_LEN: begin
            if (dp_status.task_bad) begin
               dp_cmd.sel  = SEL_TASK;
               dp_cmd.emit = dp_status.out_free;
            end else begin
               dp_cmd.op = OP_LEN_RD;
            end
         end
         S_F_SET: begin
            dp_cmd.op = OP_LEN_SET;
         end
         S_F_DEP: begin
            dp_cmd.op = OP_DEP_RD;
         end
         S_F_UPD: begin
            dp_cmd.kind = KIND_READY;
            dp_cmd.sel  = SEL_DEP;
            dp_cmd.last = 1'b0;
            if (!ready_emit || dp_status.out_free) begin
               dp_cmd.op   = OP_DEP_UPD;
               dp_cmd.emit = ready_emit;
            end
         end
         S_F_FREE: begin
            dp_cmd.kind = dp_status.stack_full ? KIND_ERROR : KIND_DONE;
            dp_cmd.sel  = SEL_TASK;
            if (dp_status.out_free) begin
               dp_cmd.op   = OP_FREE;
               dp_cmd.emit = 1'b1;
            end
         end
         S_ERR: begin
            dp_cmd.emit = dp_status.out_free;
         end
         default: begin
            dp_cmd.op = OP_NONE;
         end
      endcase
   end

endmodule

@@ src/tdt_datapath.sv @@
// Datapath of the task dependence tracker: slot tables, free stack, edge rows, result register.
// Depends on tdt_pkg; driven by tdt_ctrl.
module tdt_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [tdt_pkg::FIELD_W-1:0]  req_pred_count,
   input  logic [tdt_pkg::FIELD_W-1:0]  req_producer_slot,
   input  logic [tdt_pkg::FIELD_W-1:0]  req_task_slot,
   input  tdt_pkg::dp_cmd_type          dp_cmd,
   output tdt_pkg::dp_status_type       dp_status,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_kind,
   output logic [tdt_pkg::FIELD_W-1:0]  rsp_slot_id,
   output logic                         rsp_last
);
   import tdt_pkg::*;

   // latched request
   logic [FIELD_W-1:0] pred_ff, prod_ff, task_ff;
   logic [SLOT_W-1:0]  prod_addr, task_addr;

   // free stack
   logic [SLOT_W-1:0]     stk_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] stk_vld_ff;
   logic [SLOT_W-1:0]     stk_rd_ff, stk_raddr_ff, stack_s;
   logic                  stk_rvld_ff;
   logic [TOP_W-1:0]      free_top_ff, top_dec;
   logic [SLOT_W-1:0]     top_m1, top_idx;

   // pending counts
   logic [PEND_W-1:0]     pend_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] pend_vld_ff;
   logic [PEND_W-1:0]     pend_rd_ff, pend_val, pend_wdata;
   logic                  pend_rvld_ff, pend_we;
   logic [SLOT_W-1:0]     pend_waddr;

   // list lengths
   logic [LEN_W-1:0]      len_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] len_vld_ff;
   logic [LEN_W-1:0]      len_rd_ff, len_val, len_clamp, len_wdata;
   logic                  len_rvld_ff, len_we;
   logic [SLOT_W-1:0]     len_waddr, len_raddr;

   // edge matrix, one row per consumer, bit per producer
   logic [SLOT_COUNT-1:0] edge_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] edge_vld_ff;
   logic [SLOT_COUNT-1:0] edge_rd_ff, edge_val, edge_wdata, prod_bit, task_bit;
   logic                  edge_rvld_ff, edge_we;
   logic [SLOT_W-1:0]     edge_waddr, edge_raddr;

   // dependent lists
   logic [FIELD_W-1:0]    dep_mem [DEP_N];
   logic [FIELD_W-1:0]    dep_rd_ff;
   logic [DEP_AW-1:0]     dep_raddr, dep_waddr;
   logic [SLOT_W-1:0]     dep_slot;

   // walk state
   logic [SLOT_W-1:0]     cur_ff;
   logic [LEN_W-1:0]      len_ff, idx_ff, idx_next;
   logic                  dep_bad;

   // result register
   logic                  rsp_valid_ff, out_free;
   kind_type              rsp_kind_ff;
   logic [FIELD_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                  rsp_last_ff;

   assign prod_addr = SLOT_W'(prod_ff);
   assign task_addr = SLOT_W'(task_ff);
   assign dep_slot  = SLOT_W'(dep_rd_ff);
   assign top_dec   = free_top_ff - TOP_W'(1);
   assign top_m1    = top_dec[SLOT_W-1:0];
   assign top_idx   = free_top_ff[SLOT_W-1:0];
   assign idx_next  = idx_ff + LEN_W'(1);
   assign dep_bad   = CMP_W'(dep_rd_ff) >= CMP_W'(SLOT_COUNT);

   // entries never written read as their reset value
   assign stack_s  = stk_rvld_ff ? stk_rd_ff : stk_raddr_ff;
   assign pend_val = pend_rvld_ff ? pend_rd_ff : '0;
   assign len_val  = len_rvld_ff ? len_rd_ff : '0;
   assign edge_val = edge_rvld_ff ? edge_rd_ff : '0;
   assign len_clamp = (len_val > LEN_W'(LIST_DEPTH)) ? LEN_W'(LIST_DEPTH) : len_val;

   assign prod_bit = {{(SLOT_COUNT-1){1'b0}}, 1'b1} << prod_addr;
   assign task_bit = {{(SLOT_COUNT-1){1'b0}}, 1'b1} << task_addr;

   always_ff @(posedge clock) begin
      if (dp_cmd.op == OP_LOAD) begin
         pred_ff <= req_pred_count;
         prod_ff <= req_producer_slot;
         task_ff <= req_task_slot;
      end
   end

   // ---------------- free stack ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         free_top_ff <= TOP_W'(SLOT_COUNT);
         stk_vld_ff  <= '0;
      end else if (dp_cmd.op == OP_POP) begin
         free_top_ff <= top_dec;
      end else if (dp_cmd.op == OP_FREE && !dp_status.stack_full) begin
         free_top_ff         <= free_top_ff + TOP_W'(1);
         stk_vld_ff[top_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.op == OP_FREE && !dp_status.stack_full) begin
         stk_mem[top_idx] <= task_addr;
      end
      if (dp_cmd.op == OP_POP) begin
         stk_rd_ff    <= stk_mem[top_m1];
         stk_rvld_ff  <= stk_vld_ff[top_m1];
         stk_raddr_ff <= top_m1;
      end
   end

   // ---------------- write port selection ----------------
   always_comb begin
      pend_we    = 1'b0;
      pend_waddr = task_addr;
      pend_wdata = '0;
      len_we     = 1'b0;
      len_waddr  = task_addr;
      len_wdata  = '0;
      edge_we    = 1'b0;
      edge_waddr = task_addr;
      edge_wdata = edge_val | prod_bit;
      unique case (dp_cmd.op)
         OP_GRANT: begin
            pend_we    = 1'b1;
            pend_waddr = stack_s;
            pend_wdata = PEND_W'(pred_ff);
            len_we     = 1'b1;
            len_waddr  = stack_s;
         end
         OP_EDGE_ADD: begin
            len_we     = 1'b1;
            len_waddr  = prod_addr;
            len_wdata  = len_val + LEN_W'(1);
            edge_we    = 1'b1;
         end
         OP_DEP_UPD: begin
            pend_we    = !dep_bad && (pend_val != '0);
            pend_waddr = dep_slot;
            pend_wdata = pend_val - PEND_W'(1);
            edge_we    = !dep_bad;
            edge_waddr = dep_slot;
            edge_wdata = edge_val & ~task_bit;
         end
         OP_FREE: begin
            pend_we    = 1'b1;
            len_we     = 1'b1;
         end
         default: begin
            pend_we = 1'b0;
         end
      endcase
   end

   assign len_raddr  = (dp_cmd.op == OP_EDGE_RD) ? prod_addr : task_addr;
   assign edge_raddr = (dp_cmd.op == OP_EDGE_RD) ? task_addr : dep_slot;
   assign dep_waddr  = DEP_AW'(prod_addr) * DEP_AW'(LIST_DEPTH)
                       + DEP_AW'(len_val[IDX_W-1:0]);
   assign dep_raddr  = (dp_cmd.op == OP_LEN_SET)
                       ? DEP_AW'(task_addr) * DEP_AW'(LIST_DEPTH)
                       : DEP_AW'(task_addr) * DEP_AW'(LIST_DEPTH)
                         + DEP_AW'(idx_next[IDX_W-1:0]);

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= '0;
         len_vld_ff  <= '0;
         edge_vld_ff <= '0;
      end else begin
         if (pend_we) begin
            pend_vld_ff[pend_waddr] <= 1'b1;
         end
         if (len_we) begin
            len_vld_ff[len_waddr] <= 1'b1;
         end
         if (edge_we) begin
            edge_vld_ff[edge_waddr] <= 1'b1;
         end
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_waddr] <= pend_wdata;
      end
      if (dp_cmd.op == OP_DEP_RD) begin
         pend_rd_ff   <= pend_mem[dep_slot];
         pend_rvld_ff <= pend_vld_ff[dep_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      if (dp_cmd.op == OP_EDGE_RD || dp_cmd.op == OP_LEN_RD) begin
         len_rd_ff   <= len_mem[len_raddr];
         len_rvld_ff <= len_vld_ff[len_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      if (dp_cmd.op == OP_EDGE_RD || dp_cmd.op == OP_DEP_RD) begin
         edge_rd_ff   <= edge_mem[edge_raddr];
         edge_rvld_ff <= edge_vld_ff[edge_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.op == OP_EDGE_ADD) begin
         dep_mem[dep_waddr] <= task_ff;
      end
      if (dp_cmd.op == OP_LEN_SET || dp_cmd.op == OP_DEP_UPD) begin
         dep_rd_ff <= dep_mem[dep_raddr];
      end
   end

   // ---------------- walk registers ----------------
   always_ff @(posedge clock) begin
      if (dp_cmd.op == OP_GRANT) begin
         cur_ff <= stack_s;
      end
      if (dp_cmd.op == OP_LEN_SET) begin
         len_ff <= len_clamp;
         idx_ff <= '0;
      end else if (dp_cmd.op == OP_DEP_UPD) begin
         idx_ff <= idx_next;
      end
   end

   // ---------------- result register ----------------
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (dp_cmd.sel)
         SEL_ZERO:  rsp_slot_in = '0;
         SEL_PROD:  rsp_slot_in = prod_ff;
         SEL_TASK:  rsp_slot_in = task_ff;
         SEL_STACK: rsp_slot_in = FIELD_W'(stack_s);
         SEL_CUR:   rsp_slot_in = FIELD_W'(cur_ff);
         SEL_DEP:   rsp_slot_in = dep_rd_ff;
         default:   rsp_slot_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.emit) begin
         rsp_kind_ff <= dp_cmd.kind;
         rsp_slot_ff <= rsp_slot_in;
         rsp_last_ff <= dp_cmd.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_slot_id = rsp_slot_ff;
   assign rsp_last    = rsp_last_ff;

   // ---------------- status ----------------
   assign dp_status.pred_zero   = (pred_ff == '0);
   assign dp_status.prod_bad    = CMP_W'(prod_ff) >= CMP_W'(SLOT_COUNT);
   assign dp_status.task_bad    = CMP_W'(task_ff) >= CMP_W'(SLOT_COUNT);
   assign dp_status.dep_bad     = dep_bad;
   assign dp_status.stack_empty = (free_top_ff == '0);
   assign dp_status.stack_full  = free_top_ff >= TOP_W'(SLOT_COUNT);
   assign dp_status.edge_hit    = edge_val[prod_addr];
   assign dp_status.list_full   = len_val >= LEN_W'(LIST_DEPTH);
   assign dp_status.len_zero    = (len_clamp == '0);
   assign dp_status.dep_last    = (idx_next == len_ff);
   assign dp_status.pend_one    = (pend_val == PEND_W'(1));
   assign dp_status.out_free    = out_free;

endmodule
